// ===== rtl/tbli_pkg.sv =====
// Shared types and constants for the sorted-table linear interpolator.
// Used by tbli_mem, tbli_muldiv and table_bisect_linear_interpolator_core.
package tbli_pkg;

  localparam int XW   = 48;  // abscissa width
  localparam int YW   = 32;  // ordinate width
  localparam int IW   = 10;  // entry index / interval index width
  localparam int CFGW = 11;  // entries_in_use register width
  localparam int QW   = 34;  // quotient bits kept by the divider
  localparam int PW   = XW + YW;  // product width

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] RC_INSIDE = 2'd0;
  localparam logic [1:0] RC_BELOW  = 2'd1;
  localparam logic [1:0] RC_ABOVE  = 2'd2;

  localparam logic [CFGW-1:0] ENTRIES_RESET = 11'd1024;

  typedef struct packed {
    logic          op;
    logic [IW-1:0] entry_index;
    logic [XW-1:0] abscissa;
    logic [YW-1:0] ordinate;
  } in_item_t;

  typedef struct packed {
    logic [YW-1:0] interpolated_value;
    logic [IW-1:0] interval_low;
    logic [1:0]    range_case;
  } out_item_t;

  typedef struct packed {
    logic [XW-1:0] abscissa;
    logic [YW-1:0] ordinate;
  } entry_t;

  typedef struct packed {
    logic          start;
    logic [XW-1:0] a;
    logic [YW-1:0] b;
    logic [XW-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic          big;
    logic [QW-1:0] q;
  } div_rsp_t;

endpackage

// ===== rtl/table_bisect_linear_interpolator_core.sv =====
// Sorted-table linear interpolator: a write transfer stores one (abscissa, ordinate)
// entry; a query transfer bisects the first entries_in_use entries with one memory
// read per step, then runs the shared multiply/divide unit. The query time is set by
// the 67-step multiply/divide unit and the single table read port; a query whose
// interval, offset or ordinate step is zero skips the unit. Input stall stays high
// for the whole query; a finished result waits in the output register without
// blocking the next transfer. Table entries read before being written are
// undefined; the user must write entries_in_use only while idle; the block itself
// does not enforce it.
module table_bisect_linear_interpolator_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tbli_pkg::CFGW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tbli_pkg::in_item_t           in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tbli_pkg::out_item_t          out_o
);
  import tbli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_CMP_FIRST = 10'b0000000010,
    ST_CMP_LAST  = 10'b0000000100,
    ST_SEARCH    = 10'b0000001000,
    ST_LD_LO     = 10'b0000010000,
    ST_LD_HI     = 10'b0000100000,
    ST_CALC      = 10'b0001000000,
    ST_START     = 10'b0010000000,
    ST_WAIT      = 10'b0100000000,
    ST_FINISH    = 10'b1000000000
  } state_e;

  state_e          state_q, state_d;
  logic [CFGW-1:0] cfg_q;
  logic [AW-1:0]   last_c;
  logic [AW-1:0]   last_q, last_d;
  logic [AW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [1:0]      rc_q, rc_d;
  logic [XW-1:0]   x_q, x_d;
  logic [XW-1:0]   x0_q, x0_d;
  logic [YW-1:0]   y0_q, y0_d;
  logic [XW:0]     dx_q, dx_d, den_q, den_d;
  logic [YW:0]     dy_q, dy_d;
  logic            neg_q, neg_d;
  logic [QW:0]     q_q, q_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            in_accept, wr_en, fin_load;
  logic [AW-1:0]   raddr;
  entry_t          rdata, wdata;
  logic            ge_mid;
  logic [AW-1:0]   lo_n, hi_n;
  logic [AW:0]     mid_sum;
  logic [XW:0]     mag_dx, mag_den;
  logic [YW:0]     mag_dy;
  logic [QW+2:0]   r_sum;
  logic [YW-1:0]   r_clamp;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign wr_en      = in_accept && (in_i.op == OP_WRITE) &&
                      (32'(in_i.entry_index) < TABLE_DEPTH);
  assign wdata      = '{abscissa: in_i.abscissa, ordinate: in_i.ordinate};

  tbli_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(in_i.entry_index)),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tbli_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // effective last index from the entry count, clamped to 2 .. TABLE_DEPTH entries
  always_comb begin
    if (cfg_q < CFGW'(2)) begin
      last_c = AW'(1);
    end else if (32'(cfg_q) > TABLE_DEPTH) begin
      last_c = AW'(TABLE_DEPTH - 1);
    end else begin
      last_c = AW'(cfg_q - CFGW'(1));
    end
  end

  // bisection step on the entry read at mid_q
  always_comb begin
    ge_mid  = (x_q >= rdata.abscissa);
    lo_n    = ge_mid ? mid_q : lo_q;
    hi_n    = ge_mid ? hi_q : mid_q;
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  end

  always_comb begin
    mag_dx  = dx_q[XW] ? (~dx_q + 1'b1) : dx_q;
    mag_den = den_q[XW] ? (~den_q + 1'b1) : den_q;
    mag_dy  = dy_q[YW] ? (~dy_q + 1'b1) : dy_q;
  end

  always_comb begin
    if (neg_q) begin
      r_sum = {5'b0, y0_q} - {2'b0, q_q};
    end else begin
      r_sum = {5'b0, y0_q} + {2'b0, q_q};
    end
    if (r_sum[QW+2]) begin
      r_clamp = '0;
    end else if (r_sum[QW+1:YW] != '0) begin
      r_clamp = '1;
    end else begin
      r_clamp = r_sum[YW-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    last_d   = last_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    rc_d     = rc_q;
    x_d      = x_q;
    x0_d     = x0_q;
    y0_d     = y0_q;
    dx_d     = dx_q;
    den_d    = den_q;
    dy_d     = dy_q;
    neg_d    = neg_q;
    q_d      = q_q;
    raddr    = '0;
    fin_load = 1'b0;
    div_req  = '{start: 1'b0, a: mag_dx[XW-1:0], b: mag_dy[YW-1:0], d: mag_den[XW-1:0]};
    case (state_q)
      ST_IDLE: begin
        if (in_accept && in_i.op == OP_QUERY) begin
          x_d     = in_i.abscissa;
          last_d  = last_c;
          state_d = ST_CMP_FIRST;
        end
      end
      ST_CMP_FIRST: begin
        raddr = last_q;
        if (x_q < rdata.abscissa) begin
          lo_d    = '0;
          hi_d    = AW'(1);
          rc_d    = RC_BELOW;
          state_d = ST_LD_LO;
        end else begin
          state_d = ST_CMP_LAST;
        end
      end
      ST_CMP_LAST: begin
        raddr = last_q >> 1;
        if (x_q >= rdata.abscissa) begin
          lo_d    = last_q - AW'(1);
          hi_d    = last_q;
          rc_d    = RC_ABOVE;
          state_d = ST_LD_LO;
        end else begin
          lo_d = '0;
          hi_d = last_q;
          rc_d = RC_INSIDE;
          if (last_q > AW'(1)) begin
            mid_d   = last_q >> 1;
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_LD_LO;
          end
        end
      end
      ST_SEARCH: begin
        lo_d  = lo_n;
        hi_d  = hi_n;
        mid_d = mid_sum[AW:1];
        raddr = mid_sum[AW:1];
        if (hi_n - lo_n <= AW'(1)) begin
          state_d = ST_LD_LO;
        end
      end
      ST_LD_LO: begin
        raddr   = lo_q;
        state_d = ST_LD_HI;
      end
      ST_LD_HI: begin
        raddr   = hi_q;
        x0_d    = rdata.abscissa;
        y0_d    = rdata.ordinate;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        dx_d    = {1'b0, x_q} - {1'b0, x0_q};
        den_d   = {1'b0, rdata.abscissa} - {1'b0, x0_q};
        dy_d    = {1'b0, rdata.ordinate} - {1'b0, y0_q};
        state_d = ST_START;
      end
      ST_START: begin
        neg_d = dx_q[XW] ^ dy_q[YW] ^ den_q[XW];
        if (den_q == '0 || dx_q == '0 || dy_q == '0) begin
          q_d     = '0;
          state_d = ST_FINISH;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          q_d     = div_rsp.big ? {1'b1, QW'(0)} : {1'b0, div_rsp.q};
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          fin_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fin_load) begin
      out_valid_d              = 1'b1;
      out_d.interpolated_value = r_clamp;
      out_d.interval_low       = IW'(lo_q);
      out_d.range_case         = rc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= ENTRIES_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    rc_q   <= rc_d;
    x_q    <= x_d;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    dx_q   <= dx_d;
    den_q  <= den_d;
    dy_q   <= dy_d;
    neg_q  <= neg_d;
    q_q    <= q_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_query_enters_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.op == OP_QUERY |=> state_q == ST_CMP_FIRST)
    else $error("query transfer did not start the search");

  a_bracket_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> lo_q < mid_q && mid_q < hi_q && hi_q <= last_q)
    else $error("bisection bracket out of order");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> den_q != '0 && dx_q != '0 && dy_q != '0)
    else $error("divide started on a degenerate interval");

  a_done_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT && div_rsp.done |=> state_q == ST_FINISH)
    else $error("divide result not taken");

endmodule

// ===== rtl/tbli_mem.sv =====
// Table memory: one write port, one read port with registered read data.
// Depends on tbli_pkg for the entry type.
module tbli_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  tbli_pkg::entry_t wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output tbli_pkg::entry_t rdata_o
);
  import tbli_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tbli_muldiv.sv =====
// Iterative (a * b) / d unit around one shared 49-bit adder/subtractor:
// 32 shift-add multiply steps, one overflow check, 34 restoring divide steps.
// Depends on tbli_pkg for the request/response structs and widths.
module tbli_muldiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbli_pkg::div_req_t req_i,
  output tbli_pkg::div_rsp_t rsp_o
);
  import tbli_pkg::*;

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_CHK  = 4'b0100,
    U_DIV  = 4'b1000
  } ustate_e;

  localparam int AccW = PW + 2;
  localparam logic [5:0] MulLast = 6'(YW - 1);
  localparam logic [5:0] DivLast = 6'(QW - 1);

  ustate_e        state_q, state_d;
  logic [5:0]     cnt_q, cnt_d;
  logic           done_q, done_d;
  logic           big_q, big_d;
  logic [XW-1:0]  a_q, a_d;
  logic [XW-1:0]  d_q, d_d;
  logic [AccW-1:0] acc_q, acc_d;

  logic [XW:0]    opa, opb;
  logic           cin;
  logic [XW+1:0]  sum;

  // shared adder
  always_comb begin
    opa = '0;
    opb = '0;
    cin = 1'b0;
    case (state_q)
      U_MUL: begin
        opa = {1'b0, acc_q[PW-1:YW]};
        opb = acc_q[0] ? {1'b0, a_q} : '0;
      end
      U_CHK: begin
        opa = {1'b0, acc_q[AccW-1:QW]};
        opb = ~{1'b0, d_q};
        cin = 1'b1;
      end
      U_DIV: begin
        opa = acc_q[AccW-1:QW-1];
        opb = ~{1'b0, d_q};
        cin = 1'b1;
      end
      default: ;
    endcase
    sum = {1'b0, opa} + {1'b0, opb} + (XW+2)'(cin);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    big_d   = big_q;
    a_d     = a_q;
    d_d     = d_q;
    acc_d   = acc_q;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.a;
          d_d     = req_i.d;
          acc_d   = {(AccW-YW)'(0), req_i.b};
          cnt_d   = '0;
          state_d = U_MUL;
        end
      end
      U_MUL: begin
        acc_d = {2'b00, sum[XW:0], acc_q[YW-1:1]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == MulLast) begin
          cnt_d   = '0;
          state_d = U_CHK;
        end
      end
      U_CHK: begin
        // quotient would reach 2^34 when (P >> 34) >= d
        if (sum[XW+1]) begin
          big_d   = 1'b1;
          done_d  = 1'b1;
          state_d = U_IDLE;
        end else begin
          big_d   = 1'b0;
          state_d = U_DIV;
        end
      end
      U_DIV: begin
        if (sum[XW+1]) begin
          acc_d = {sum[XW-1:0], acc_q[QW-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[AccW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DivLast) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    big_q <= big_d;
    a_q   <= a_d;
    d_q   <= d_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.big  = big_q;
  assign rsp_o.q    = acc_q[QW-1:0];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == U_IDLE)
    else $error("muldiv started while busy");

  a_done_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == U_IDLE)
    else $error("muldiv done while not idle");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == U_DIV |-> cnt_q <= DivLast)
    else $error("muldiv divide count overrun");

  a_mul_to_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == U_MUL && cnt_q == MulLast |=> state_q == U_CHK)
    else $error("muldiv multiply phase length");

endmodule
